// File: src/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Types and constants for the keyed record table: item layouts, record
// layout, command codes and controller states.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int WORD_W    = 32;
  localparam int COUNT_W   = 5;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [WORD_W-1:0]  word_t;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_READ = 2'd2,
    CMD_LIST = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT,
    ST_LIST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_t  cmd;
    word_t key;
    word_t year_in;
    word_t course_a_in;
    word_t grade_a_in;
    word_t course_b_in;
    word_t grade_b_in;
    word_t course_c_in;
    word_t grade_c_in;
  } in_item_t;

  typedef struct packed {
    logic   ok;
    word_t  key_out;
    word_t  year_out;
    word_t  course_a_out;
    word_t  grade_a_out;
    word_t  course_b_out;
    word_t  grade_b_out;
    word_t  course_c_out;
    word_t  grade_c_out;
    count_t count;
    logic   full_res;
    logic   last;
  } out_item_t;

  typedef struct packed {
    word_t key;
    word_t year;
    word_t course_a;
    word_t grade_a;
    word_t course_b;
    word_t grade_b;
    word_t course_c;
    word_t grade_c;
  } record_t;

  localparam int REC_W = $bits(record_t);

endpackage

// File: src/keyed_record_table.sv
// ----------------------------------------------------------------------------
// keyed_record_table
// Packed table of records (key plus seven payload words) in one RAM, kept in
// insertion order: add, delete with compaction, read by key, list keys.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_data  (krt_pkg::in_item_t)
//   out     | output    | out_valid / out_ready | out_data (krt_pkg::out_item_t)
//
// Add writes the record and gives its result. Read and delete scan one entry per
// cycle through the single RAM read port until a match or the last entry;
// delete then moves one later record down per cycle. List gives one item per
// cycle while the output is free, once the first entry has been read.
// Reset (rst_n low, synchronous) empties the table; RAM contents are kept.
// A stalled output holds the controller; a new input item is taken in idle
// even while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module keyed_record_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  krt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output krt_pkg::out_item_t out_data
);

  krt_pkg::state_t    state_r, state_nxt;
  krt_pkg::in_item_t  item_r, item_nxt;
  krt_pkg::cnt_t      cnt_r, cnt_nxt;
  krt_pkg::idx_t      ptr_r, ptr_nxt;
  krt_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r;
  krt_pkg::out_item_t out_data_r;

  logic               wr_en;
  krt_pkg::idx_t      wr_addr;
  krt_pkg::record_t   wr_data;
  logic               rd_en;
  krt_pkg::idx_t      rd_addr;
  krt_pkg::record_t   rd_data;

  logic               out_free;
  logic               emit;
  krt_pkg::out_item_t emit_item;
  logic               more;
  logic               hit;
  krt_pkg::idx_t      ptr_inc;
  krt_pkg::record_t   add_rec;

  krt_ram #(
    .WIDTH (krt_pkg::REC_W),
    .DEPTH (krt_pkg::ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign ptr_inc  = ptr_r + krt_pkg::idx_t'(1);
  assign more     = (krt_pkg::cnt_t'(ptr_r) + krt_pkg::cnt_t'(1)) < cnt_r;
  assign hit      = (rd_data.key == item_r.key);

  always_comb begin
    add_rec.key      = item_r.key;
    add_rec.year     = item_r.year_in;
    add_rec.course_a = item_r.course_a_in;
    add_rec.grade_a  = item_r.grade_a_in;
    add_rec.course_b = item_r.course_b_in;
    add_rec.grade_b  = item_r.grade_b_in;
    add_rec.course_c = item_r.course_c_in;
    add_rec.grade_c  = item_r.grade_c_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= krt_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    ptr_r  <= ptr_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = ptr_r;
    wr_data   = rd_data;
    rd_en     = 1'b0;
    rd_addr   = ptr_inc;
    emit      = 1'b0;
    emit_item = '0;

    unique case (state_r)
      krt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          ptr_nxt   = '0;
          state_nxt = krt_pkg::ST_EXEC;
        end
      end

      krt_pkg::ST_EXEC: begin
        res_nxt = '0;
        if (item_r.cmd == krt_pkg::CMD_ADD) begin
          if (cnt_r != krt_pkg::cnt_t'(krt_pkg::ENTRIES)) begin
            wr_en           = 1'b1;
            wr_addr         = cnt_r[krt_pkg::IDX_W-1:0];
            wr_data         = add_rec;
            cnt_nxt         = cnt_r + krt_pkg::cnt_t'(1);
            res_nxt.ok      = 1'b1;
            res_nxt.key_out = item_r.key;
          end
          state_nxt = krt_pkg::ST_FINISH;
        end else if (cnt_r == '0) begin
          state_nxt = krt_pkg::ST_FINISH;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = (item_r.cmd == krt_pkg::CMD_LIST) ? krt_pkg::ST_LIST
                                                          : krt_pkg::ST_SCAN;
        end
      end

      krt_pkg::ST_SCAN: begin
        if (hit) begin
          res_nxt         = '0;
          res_nxt.ok      = 1'b1;
          res_nxt.key_out = rd_data.key;
          if (item_r.cmd == krt_pkg::CMD_READ) begin
            res_nxt.year_out     = rd_data.year;
            res_nxt.course_a_out = rd_data.course_a;
            res_nxt.grade_a_out  = rd_data.grade_a;
            res_nxt.course_b_out = rd_data.course_b;
            res_nxt.grade_b_out  = rd_data.grade_b;
            res_nxt.course_c_out = rd_data.course_c;
            res_nxt.grade_c_out  = rd_data.grade_c;
            state_nxt            = krt_pkg::ST_FINISH;
          end else if (more) begin
            rd_en     = 1'b1;
            ptr_nxt   = ptr_inc;
            state_nxt = krt_pkg::ST_SHIFT;
          end else begin
            cnt_nxt   = cnt_r - krt_pkg::cnt_t'(1);
            state_nxt = krt_pkg::ST_FINISH;
          end
        end else if (more) begin
          rd_en   = 1'b1;
          ptr_nxt = ptr_inc;
        end else begin
          res_nxt   = '0;
          state_nxt = krt_pkg::ST_FINISH;
        end
      end

      krt_pkg::ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r - krt_pkg::idx_t'(1);
        wr_data = rd_data;
        if (more) begin
          rd_en   = 1'b1;
          ptr_nxt = ptr_inc;
        end else begin
          cnt_nxt   = cnt_r - krt_pkg::cnt_t'(1);
          state_nxt = krt_pkg::ST_FINISH;
        end
      end

      krt_pkg::ST_LIST: begin
        if (out_free) begin
          emit              = 1'b1;
          emit_item.ok      = 1'b1;
          emit_item.key_out = rd_data.key;
          emit_item.last    = !more;
          if (more) begin
            rd_en   = 1'b1;
            ptr_nxt = ptr_inc;
          end else begin
            state_nxt = krt_pkg::ST_IDLE;
          end
        end
      end

      krt_pkg::ST_FINISH: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_item      = res_r;
          emit_item.last = 1'b1;
          state_nxt      = krt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = krt_pkg::ST_IDLE;
      end
    endcase

    emit_item.count    = krt_pkg::count_t'(cnt_r);
    emit_item.full_res = (cnt_r == krt_pkg::cnt_t'(krt_pkg::ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/krt_ram.sv
// ----------------------------------------------------------------------------
// krt_ram
// Simple dual-port RAM: one write port, one read port with registered data
// that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
